@@ rtl/bmsi_pkg.sv @@
// ----------------------------------------------------------------------------
// bmsi_pkg
// Shared types and constants for the bank mapper with scanline interrupt.
// ----------------------------------------------------------------------------
package bmsi_pkg;

    // Kinds of input item.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_PRG   = 2'd2;
    localparam logic [1:0] REQ_CHR   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FOUR_SCREEN = 2'd0;
    localparam logic [1:0] CFG_REV_B_IRQ   = 2'd1;
    localparam logic [1:0] CFG_PRG_MASK    = 2'd2;
    localparam logic [1:0] CFG_CHR_MASK    = 2'd3;

    // Mapper register codes: {A14, A13, A0} of a write at or above 0x8000.
    localparam logic [2:0] MREG_BANK_SEL  = 3'b000;
    localparam logic [2:0] MREG_BANK_DATA = 3'b001;
    localparam logic [2:0] MREG_MIRROR    = 3'b010;
    localparam logic [2:0] MREG_PRG_RAM   = 3'b011;
    localparam logic [2:0] MREG_LATCH     = 3'b100;
    localparam logic [2:0] MREG_RELOAD    = 3'b101;
    localparam logic [2:0] MREG_DISABLE   = 3'b110;
    localparam logic [2:0] MREG_ENABLE    = 3'b111;

    // Mirroring codes on the output.
    localparam logic [1:0] MIRROR_FOUR = 2'd2;

    // Last visible scanline that clocks the counter.
    localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

    // Fixed program banks before masking.
    localparam logic [5:0] PRG_SECOND_LAST = 6'h3E;
    localparam logic [5:0] PRG_LAST        = 6'h3F;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] cpu_addr;
        logic [7:0]  write_data;
        logic [12:0] ppu_addr;
        logic [8:0]  scanline;
        logic        rendering_on;
    } t_in_item;

    typedef struct packed {
        logic [5:0] prg_bank;
        logic [7:0] chr_bank;
        logic       irq_line;
        logic [1:0] mirror_mode;
    } t_out_item;

    typedef struct packed {
        logic       four_screen;
        logic       rev_b_irq;
        logic [5:0] prg_bank_mask;
        logic [7:0] chr_bank_mask;
    } t_cfg;

    typedef struct packed {
        logic [7:0]       bank_select;
        logic [7:0][7:0]  bank_regs;
        logic [7:0]       irq_latch;
        logic [7:0]       irq_counter;
        logic             irq_reload_flag;
        logic             irq_enable;
        logic             irq_pending;
        logic             mirror_bit;
    } t_map_state;

    // Bank registers after reset: R0..R7 = 0,2,4,5,6,7,0,1 (R0 in the low byte).
    localparam t_map_state MAP_RESET = '{
        bank_select:     8'd0,
        bank_regs:       64'h0100_0706_0504_0200,
        irq_latch:       8'd0,
        irq_counter:     8'd0,
        irq_reload_flag: 1'b0,
        irq_enable:      1'b0,
        irq_pending:     1'b0,
        mirror_bit:      1'b0
    };

    localparam t_cfg CFG_RESET = '{
        four_screen:   1'b0,
        rev_b_irq:     1'b1,
        prg_bank_mask: 6'h3F,
        chr_bank_mask: 8'hFF
    };

endpackage

@@ rtl/bank_mapper_scanline_irq.sv @@
// ----------------------------------------------------------------------------
// bank_mapper_scanline_irq
// Cartridge bank mapper with scanline interrupt counter, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the input channel (i_in_valid / o_in_ready, payload
//   i_in_data): register writes, scanline ticks, program lookups and pattern
//   lookups. Each word produces exactly one result word on the output
//   channel (o_out_valid / i_out_ready, payload o_out_data) holding the
//   program bank, pattern bank, interrupt line and mirroring, all taken
//   from the state after the item is applied.
//   Each word passes through the input register, then the mapper state
//   update and bank lookup fill the result register.
//   Throughput is one word per cycle while the receiver keeps up; the two
//   registers let a new word in while a finished result still waits.
//   When the receiver stalls, the result holds and the input register
//   fills; o_in_ready drops only when both are full.
//   The configuration port (i_cfg_we, i_cfg_addr, i_cfg_wdata) writes a
//   register; the user must use it only while idle, the block does not enforce it.
//   Synchronous reset clears both registers, restores the mapper state and
//   the configuration defaults; the block accepts words right after.
// ----------------------------------------------------------------------------
module bank_mapper_scanline_irq
    import bmsi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wdata
);

    t_in_item   r_in;
    logic       r_in_valid;
    t_out_item  r_out;
    logic       r_out_valid;
    t_cfg       r_cfg;

    logic       w_adv;
    logic       w_step;
    t_map_state w_cur;
    t_map_state w_next;
    t_out_item  w_result;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FOUR_SCREEN: r_cfg.four_screen   <= i_cfg_wdata[0];
                CFG_REV_B_IRQ:   r_cfg.rev_b_irq     <= i_cfg_wdata[0];
                CFG_PRG_MASK:    r_cfg.prg_bank_mask <= i_cfg_wdata[5:0];
                CFG_CHR_MASK:    r_cfg.chr_bank_mask <= i_cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Mapper state and bank translation.
    bmsi_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_item       (r_in),
        .i_cfg        (r_cfg),
        .o_state      (w_cur),
        .o_state_next (w_next)
    );

    bmsi_xlate u_xlate (
        .i_item   (r_in),
        .i_state  (w_next),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // Reset empties both pipeline registers.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_in_valid)
        else $error("pipeline not empty after reset");

    // A staged word waits unchanged while the result register is blocked.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in))
        else $error("staged word lost during stall");

    // Mapper state only moves when a word is processed.
    a_state_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!w_step) && $past(i_rst_n) |-> $stable(w_cur))
        else $error("mapper state changed without a word");

    // The interrupt is raised only by a scanline tick.
    a_irq_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_cur.irq_pending) |-> $past(w_step && r_in.req_type == REQ_TICK))
        else $error("interrupt raised without a tick");

    // The interrupt is cleared only by a register write.
    a_irq_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(w_cur.irq_pending) && $past(i_rst_n) |->
            $past(w_step && r_in.req_type == REQ_WRITE))
        else $error("interrupt cleared without a write");
`endif

endmodule

@@ rtl/bmsi_regs.sv @@
// ----------------------------------------------------------------------------
// bmsi_regs
// Mapper register file and scanline counter: decodes register writes and
// clocks the interrupt counter, giving both the held and the next state.
// ----------------------------------------------------------------------------
module bmsi_regs
    import bmsi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_in_item   i_item,
    input  t_cfg       i_cfg,
    output t_map_state o_state,
    output t_map_state o_state_next
);

    t_map_state r_state;
    t_map_state n_state;

    logic [2:0] w_reg_code;
    logic       w_tick;
    logic [7:0] w_count;

    assign w_reg_code = {i_item.cpu_addr[14:13], i_item.cpu_addr[0]};
    assign w_tick     = (i_item.req_type == REQ_TICK) &&
                        (i_item.scanline <= LAST_VISIBLE_LINE) && i_item.rendering_on;

    // Next state: the item's register write or counter clock applied.
    always_comb begin
        n_state = r_state;
        w_count = r_state.irq_counter;
        if (i_item.req_type == REQ_WRITE && i_item.cpu_addr[15]) begin
            case (w_reg_code)
                MREG_BANK_SEL:  n_state.bank_select = i_item.write_data;
                MREG_BANK_DATA: n_state.bank_regs[r_state.bank_select[2:0]] =
                                    i_item.write_data;
                MREG_MIRROR: begin
                    if (!i_cfg.four_screen) begin
                        n_state.mirror_bit = i_item.write_data[0];
                    end
                end
                MREG_PRG_RAM:   ;
                MREG_LATCH:     n_state.irq_latch = i_item.write_data;
                MREG_RELOAD:    n_state.irq_reload_flag = 1'b1;
                MREG_DISABLE: begin
                    n_state.irq_enable  = 1'b0;
                    n_state.irq_pending = 1'b0;
                end
                MREG_ENABLE:    n_state.irq_enable = 1'b1;
                default:        ;
            endcase
        end else if (w_tick) begin
            // Reload from the latch on zero or on request, else count down.
            if (r_state.irq_counter == 8'd0 || r_state.irq_reload_flag) begin
                w_count                 = r_state.irq_latch;
                n_state.irq_reload_flag = 1'b0;
            end else begin
                w_count = r_state.irq_counter - 8'd1;
            end
            n_state.irq_counter = w_count;
            if ((r_state.irq_counter != 8'd0 || i_cfg.rev_b_irq) &&
                w_count == 8'd0 && r_state.irq_enable) begin
                n_state.irq_pending = 1'b1;
            end
        end
    end

    // State register, updated once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MAP_RESET;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    assign o_state      = r_state;
    assign o_state_next = n_state;

endmodule

@@ rtl/bmsi_xlate.sv @@
// ----------------------------------------------------------------------------
// bmsi_xlate
// Bank translation: maps the item's program and pattern addresses to banks
// using the updated mapper state, and forms the interrupt and mirroring bits.
// ----------------------------------------------------------------------------
module bmsi_xlate
    import bmsi_pkg::*;
(
    input  t_in_item   i_item,
    input  t_map_state i_state,
    input  t_cfg       i_cfg,
    output t_out_item  o_result
);

    logic [1:0] w_prg_slot;
    logic [5:0] w_prg_raw;
    logic [2:0] w_chr_slot;
    logic [2:0] w_chr_idx;
    logic [7:0] w_chr_reg;
    logic [7:0] w_chr_raw;

    // Program slot: bit 6 swaps the first and third 8K windows.
    always_comb begin
        w_prg_slot = i_item.cpu_addr[14:13];
        if (i_state.bank_select[6] && !w_prg_slot[0]) begin
            w_prg_slot[1] = ~w_prg_slot[1];
        end
        case (w_prg_slot)
            2'd0:    w_prg_raw = i_state.bank_regs[6][5:0];
            2'd1:    w_prg_raw = i_state.bank_regs[7][5:0];
            2'd2:    w_prg_raw = PRG_SECOND_LAST;
            default: w_prg_raw = PRG_LAST;
        endcase
    end

    // Pattern slot: bit 7 swaps the two 4K halves; the low half uses 2K pairs.
    always_comb begin
        w_chr_slot = i_item.ppu_addr[12:10] ^ {i_state.bank_select[7], 2'b00};
        if (!w_chr_slot[2]) begin
            w_chr_idx = {2'b00, w_chr_slot[1]};
        end else begin
            w_chr_idx = w_chr_slot - 3'd2;
        end
        w_chr_reg = i_state.bank_regs[w_chr_idx];
        if (!w_chr_slot[2]) begin
            w_chr_raw = {w_chr_reg[7:1], w_chr_slot[0]};
        end else begin
            w_chr_raw = w_chr_reg;
        end
    end

    always_comb begin
        o_result.prg_bank    = w_prg_raw & i_cfg.prg_bank_mask;
        o_result.chr_bank    = w_chr_raw & i_cfg.chr_bank_mask;
        o_result.irq_line    = i_state.irq_pending;
        o_result.mirror_mode = i_cfg.four_screen ? MIRROR_FOUR
                                                 : {1'b0, i_state.mirror_bit};
    end

endmodule
